/* rtl/core/lsh_pkg.sv */
// ----------------------------------------------------------------------------
// lsh_pkg
// Shared types, constants and helpers for the LSH-512 hash engine.
// ----------------------------------------------------------------------------
package lsh_pkg;

    localparam int NSTEPS = 28;

    localparam logic [63:0] SC_INIT [8] = '{
        64'h97884283c938982a, 64'hba1fca93533e2355,
        64'hc519a2e87aeb1c03, 64'h9a0fc95462af17b1,
        64'hfc3dda8ab019a82b, 64'h02825d079a895407,
        64'h79f2d0a7ee06a6f7, 64'hd76d15eed9fdf5fe
    };
    localparam int GAM [8]  = '{0, 16, 32, 48, 8, 24, 40, 56};
    localparam int SIG [16] = '{6, 4, 5, 7, 12, 15, 14, 13, 2, 0, 1, 3, 8, 11, 10, 9};
    localparam int TAU [16] = '{3, 2, 0, 1, 7, 4, 5, 6, 11, 10, 8, 9, 15, 12, 13, 14};

    localparam int ROT_A_EVEN = 23;
    localparam int ROT_B_EVEN = 59;
    localparam int ROT_A_ODD  = 7;
    localparam int ROT_B_ODD  = 3;
    localparam int SC_ROT     = 8;

    localparam logic [63:0] IV_WORD0   = 64'd64;
    localparam logic [7:0]  PAD_BYTE   = 8'h80;
    localparam logic [9:0]  BITS_MAX   = 10'd512;
    localparam logic [9:0]  BITS_MIN   = 10'd8;
    localparam logic [3:0]  FULL_COUNT = 4'd8;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_IV_START,
        ST_IV_RUN,
        ST_BYTE,
        ST_BLK_START,
        ST_BLK_RUN,
        ST_PAD,
        ST_FIN_START,
        ST_FIN_RUN,
        ST_OUT
    } state_t;

    typedef enum logic [1:0] {
        WSEL_DATA,
        WSEL_PARTIAL,
        WSEL_PAD
    } wsel_t;

    typedef struct packed {
        logic  latch;
        logic  iv_start;
        logic  blk_start;
        logic  final_blk;
        logic  write;
        wsel_t wsel;
        logic  advance;
        logic  pos_clear;
        logic  out_clear;
        logic  out_next;
    } cmd_t;

    typedef struct packed {
        logic eom;
        logic partial;
        logic full;
        logic done;
        logic last;
    } status_t;

    function automatic logic [63:0] rotl64(input logic [63:0] x, input int r);
        logic [63:0] res;
        if ((r % 64) == 0)
            res = x;
        else
            res = (x << (r % 64)) | (x >> (64 - (r % 64)));
        return res;
    endfunction

    function automatic logic [9:0] clamp_bits(input logic [9:0] b);
        logic [9:0] res;
        if (b > BITS_MAX)
            res = BITS_MAX;
        else if (b < BITS_MIN)
            res = BITS_MIN;
        else
            res = b;
        return res;
    endfunction

endpackage

/* rtl/core/lsh512_hash_engine.sv */
// ----------------------------------------------------------------------------
// lsh512_hash_engine
// LSH-512 byte-stream hash engine with selectable digest length.
// ----------------------------------------------------------------------------
// Requests are taken only in idle. A byte that fills a block loads it and
// runs 28 steps in the shared step unit; the first byte of a message first
// runs the IV compression. The final byte pads and compresses the last block,
// then output_bits/8 digest bytes follow, one a cycle while out_ready is high.
// Reset clears control state and sets output_bits to 512.
module lsh512_hash_engine (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [9:0] cfg_data,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] data_byte,
    input  logic [3:0] bit_count,
    input  logic       end_of_message,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] hash_byte,
    output logic       last_byte
);
    import lsh_pkg::*;

    cmd_t    cmd;
    status_t status;

    assign cfg_ready = in_ready;

    lsh_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    lsh_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid && cfg_ready),
        .cfg_data       (cfg_data),
        .data_byte      (data_byte),
        .bit_count      (bit_count),
        .end_of_message (end_of_message),
        .cmd            (cmd),
        .status         (status),
        .hash_byte      (hash_byte),
        .last_byte      (last_byte)
    );

endmodule

/* rtl/core/lsh_ctrl.sv */
// ----------------------------------------------------------------------------
// lsh_ctrl
// Sequencer: request intake, IV load, block compression, padding, digest out.
// ----------------------------------------------------------------------------
module lsh_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    output logic             out_valid,
    input  logic             out_ready,
    input  lsh_pkg::status_t status,
    output lsh_pkg::cmd_t    cmd
);
    import lsh_pkg::*;

    state_t state_reg, state_next;
    logic   open_reg, open_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            open_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            open_reg  <= open_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        open_next  = open_reg;
        cmd        = '0;
        cmd.wsel   = WSEL_DATA;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.latch = 1'b1;
                    if (!open_reg)
                    begin
                        cmd.pos_clear = 1'b1;
                        open_next     = 1'b1;
                        state_next    = ST_IV_START;
                    end
                    else
                        state_next = ST_BYTE;
                end
            end
            ST_IV_START:
            begin
                cmd.iv_start = 1'b1;
                state_next   = ST_IV_RUN;
            end
            ST_IV_RUN:
                if (status.done)
                    state_next = ST_BYTE;
            ST_BYTE:
            begin
                cmd.write = 1'b1;
                if (status.partial)
                begin
                    cmd.wsel   = WSEL_PARTIAL;
                    state_next = ST_FIN_START;
                end
                else
                begin
                    cmd.wsel    = WSEL_DATA;
                    cmd.advance = 1'b1;
                    if (status.full)
                        state_next = ST_BLK_START;
                    else if (status.eom)
                        state_next = ST_PAD;
                    else
                        state_next = ST_IDLE;
                end
            end
            ST_BLK_START:
            begin
                cmd.blk_start = 1'b1;
                state_next    = ST_BLK_RUN;
            end
            ST_BLK_RUN:
                if (status.done)
                    state_next = status.eom ? ST_PAD : ST_IDLE;
            ST_PAD:
            begin
                cmd.write  = 1'b1;
                cmd.wsel   = WSEL_PAD;
                state_next = ST_FIN_START;
            end
            ST_FIN_START:
            begin
                cmd.blk_start = 1'b1;
                cmd.final_blk = 1'b1;
                state_next    = ST_FIN_RUN;
            end
            ST_FIN_RUN:
                if (status.done)
                begin
                    cmd.pos_clear = 1'b1;
                    cmd.out_clear = 1'b1;
                    open_next     = 1'b0;
                    state_next    = ST_OUT;
                end
            ST_OUT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    cmd.out_next = 1'b1;
                    if (status.last)
                        state_next = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

endmodule

/* rtl/core/lsh_datapath.sv */
// ----------------------------------------------------------------------------
// lsh_datapath
// Block buffer, compression step unit, chaining value and digest selection.
// ----------------------------------------------------------------------------
module lsh_datapath (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_valid,
    input  logic [9:0]       cfg_data,
    input  logic [7:0]       data_byte,
    input  logic [3:0]       bit_count,
    input  logic             end_of_message,
    input  lsh_pkg::cmd_t    cmd,
    output lsh_pkg::status_t status,
    output logic [7:0]       hash_byte,
    output logic             last_byte
);
    import lsh_pkg::*;

    logic [9:0]  bits_reg;
    logic [7:0]  data_reg;
    logic [3:0]  cnt_reg;
    logic        eom_reg;
    logic [7:0]  pos_reg;
    logic [5:0]  idx_reg;
    logic        run_reg;
    logic        phase_reg;
    logic [4:0]  step_reg;
    logic [63:0] msg_reg [32];
    logic [63:0] t_reg  [16];
    logic [63:0] ma_reg [16];
    logic [63:0] mb_reg [16];
    logic [63:0] sc_reg [8];
    logic [63:0] cv_reg [16];

    logic [63:0] blk_word [32];
    logic [63:0] xa [8];
    logic [63:0] ya [8];
    logic [63:0] x1 [8];
    logic [63:0] y1 [8];
    logic [63:0] tt [16];
    logic [63:0] t_next [16];
    logic [63:0] h_word [8];
    logic [63:0] h_sel;
    logic [7:0]  wval;
    logic [7:0]  keep;
    logic [3:0]  cnt_eff;
    logic [9:0]  bits_eff;
    logic [6:0]  n_bytes;
    logic        last_step;

    assign cnt_eff   = (cnt_reg > FULL_COUNT) ? FULL_COUNT : cnt_reg;
    assign keep      = ~(8'hFF >> cnt_eff);
    assign bits_eff  = clamp_bits(bits_reg);
    assign n_bytes   = bits_eff[9:3];
    assign last_step = (step_reg == 5'(NSTEPS - 1));

    assign status.eom     = eom_reg;
    assign status.partial = eom_reg && (cnt_eff != FULL_COUNT);
    assign status.full    = (pos_reg == 8'hFF);
    assign status.done    = run_reg && phase_reg && last_step;
    assign status.last    = ({1'b0, idx_reg} + 7'd1) == n_bytes;

    always_comb
    begin
        case (cmd.wsel)
            WSEL_DATA:    wval = data_reg;
            WSEL_PARTIAL: wval = (data_reg & keep) | (PAD_BYTE >> cnt_eff);
            WSEL_PAD:     wval = PAD_BYTE;
            default:      wval = data_reg;
        endcase
    end

    always_comb
    begin
        for (int w = 0; w < 32; w++)
            for (int k = 0; k < 8; k++)
                if (!cmd.final_blk || (8'(w * 8 + k) <= pos_reg))
                    blk_word[w][k*8 +: 8] = msg_reg[w][k*8 +: 8];
                else
                    blk_word[w][k*8 +: 8] = 8'h00;
    end

    always_comb
    begin
        for (int l = 0; l < 8; l++)
        begin
            xa[l] = t_reg[l] ^ ma_reg[l];
            ya[l] = t_reg[l+8] ^ ma_reg[l+8];
            x1[l] = (step_reg[0] ? rotl64(xa[l] + ya[l], ROT_A_ODD)
                                 : rotl64(xa[l] + ya[l], ROT_A_EVEN)) ^ sc_reg[l];
            y1[l] = step_reg[0] ? rotl64(t_reg[l+8] + t_reg[l], ROT_B_ODD)
                                : rotl64(t_reg[l+8] + t_reg[l], ROT_B_EVEN);
            tt[l]   = t_reg[l] + y1[l];
            tt[l+8] = rotl64(y1[l], GAM[l]);
        end
        for (int i = 0; i < 16; i++)
            t_next[i] = tt[SIG[i]];
    end

    always_comb
    begin
        for (int l = 0; l < 8; l++)
            h_word[l] = cv_reg[l] ^ cv_reg[l+8];
        h_sel = h_word[idx_reg[5:3]];
    end

    assign hash_byte = h_sel[{idx_reg[2:0], 3'b000} +: 8];
    assign last_byte = status.last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bits_reg  <= BITS_MAX;
            pos_reg   <= 8'd0;
            idx_reg   <= 6'd0;
            run_reg   <= 1'b0;
            phase_reg <= 1'b0;
            step_reg  <= 5'd0;
        end
        else
        begin
            if (cfg_valid)
                bits_reg <= cfg_data;
            if (cmd.pos_clear)
                pos_reg <= 8'd0;
            else if (cmd.write && cmd.advance)
                pos_reg <= pos_reg + 8'd1;
            if (cmd.out_clear)
                idx_reg <= 6'd0;
            else if (cmd.out_next)
                idx_reg <= idx_reg + 6'd1;
            if (cmd.iv_start || cmd.blk_start)
            begin
                run_reg   <= 1'b1;
                phase_reg <= 1'b0;
                step_reg  <= 5'd0;
            end
            else if (run_reg)
            begin
                phase_reg <= ~phase_reg;
                if (phase_reg)
                begin
                    step_reg <= step_reg + 5'd1;
                    if (last_step)
                        run_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            data_reg <= data_byte;
            cnt_reg  <= bit_count;
            eom_reg  <= end_of_message;
        end
        if (cmd.write)
            msg_reg[pos_reg[7:3]][{pos_reg[2:0], 3'b000} +: 8] <= wval;
        if (cmd.iv_start)
        begin
            for (int i = 0; i < 16; i++)
            begin
                ma_reg[i] <= 64'd0;
                mb_reg[i] <= 64'd0;
            end
            for (int i = 2; i < 16; i++)
                t_reg[i] <= 64'd0;
            t_reg[0] <= IV_WORD0;
            t_reg[1] <= {54'd0, bits_eff};
            for (int l = 0; l < 8; l++)
                sc_reg[l] <= SC_INIT[l];
        end
        else if (cmd.blk_start)
        begin
            for (int i = 0; i < 16; i++)
            begin
                t_reg[i]  <= cv_reg[i];
                ma_reg[i] <= blk_word[i];
                mb_reg[i] <= blk_word[i+16];
            end
            for (int l = 0; l < 8; l++)
                sc_reg[l] <= SC_INIT[l];
        end
        else if (run_reg && !phase_reg)
        begin
            for (int l = 0; l < 8; l++)
            begin
                t_reg[l]   <= x1[l];
                t_reg[l+8] <= ya[l];
            end
        end
        else if (run_reg)
        begin
            for (int i = 0; i < 16; i++)
            begin
                t_reg[i]  <= t_next[i];
                ma_reg[i] <= mb_reg[i];
                mb_reg[i] <= mb_reg[i] + ma_reg[TAU[i]];
            end
            for (int l = 0; l < 8; l++)
                sc_reg[l] <= sc_reg[l] + rotl64(sc_reg[l], SC_ROT);
            if (last_step)
                for (int i = 0; i < 16; i++)
                    cv_reg[i] <= t_next[i] ^ mb_reg[i];
        end
    end

endmodule

/* dv/lsh512_hash_engine_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsh512_hash_engine_tb
// Streams random and corner-case messages into the LSH-512 engine across a
// range of digest lengths. Every digest byte is checked against a software
// model of the hash held in a scoreboard.
// ----------------------------------------------------------------------------
module lsh512_hash_engine_tb;
    import lsh_pkg::*;

    typedef logic [63:0] word_t;
    typedef word_t cv_t[16];
    typedef word_t blk_t[32];

    typedef struct {
        logic [7:0] hash_byte;
        logic       last_byte;
    } digest_byte_t;

    class lsh_scoreboard;
        cv_t          cv;
        blk_t         blk;
        int unsigned  pos;
        bit           open;
        logic [9:0]   out_bits;
        digest_byte_t digest_q[$];
        int           errors;
        int           bytes_checked;
        int           digests;

        function new();
            foreach (cv[i]) cv[i] = '0;
            foreach (blk[i]) blk[i] = '0;
            pos = 0;
            open = 0;
            out_bits = 10'd512;
            errors = 0;
            bytes_checked = 0;
            digests = 0;
        endfunction

        function word_t rot(word_t x, int r);
            r = r % 64;
            if (r == 0)
                return x;
            return (x << r) | (x >> (64 - r));
        endfunction

        function cv_t compress(cv_t c, blk_t m);
            word_t t[16];
            word_t ma[16];
            word_t mb[16];
            word_t nx[16];
            word_t tmp[16];
            word_t sc[8];
            word_t x;
            word_t y;
            int    ra;
            int    rb;
            cv_t   res;
            for (int l = 0; l < 16; l++)
            begin
                t[l]  = c[l];
                ma[l] = m[l];
                mb[l] = m[l + 16];
            end
            for (int l = 0; l < 8; l++)
                sc[l] = SC_INIT[l];
            for (int j = 0; j < 28; j++)
            begin
                ra = j[0] ? 7 : 23;
                rb = j[0] ? 3 : 59;
                for (int l = 0; l < 16; l++)
                    t[l] ^= ma[l];
                for (int l = 0; l < 8; l++)
                begin
                    x = t[l];
                    y = t[l + 8];
                    x = x + y;
                    x = rot(x, ra) ^ sc[l];
                    y = y + x;
                    y = rot(y, rb);
                    x = x + y;
                    y = rot(y, GAM[l]);
                    t[l] = x;
                    t[l + 8] = y;
                end
                for (int l = 0; l < 16; l++)
                    tmp[l] = t[SIG[l]];
                t = tmp;
                for (int l = 0; l < 16; l++)
                    nx[l] = mb[l] + ma[TAU[l]];
                ma = mb;
                mb = nx;
                for (int l = 0; l < 8; l++)
                    sc[l] = sc[l] + rot(sc[l], 8);
            end
            for (int l = 0; l < 16; l++)
                res[l] = t[l] ^ ma[l];
            return res;
        endfunction

        function int unsigned eff_bits();
            if (out_bits > 10'd512)
                return 512;
            if (out_bits < 10'd8)
                return 8;
            return out_bits;
        endfunction

        function void put(int unsigned p, logic [7:0] v);
            blk[p >> 3][(p & 7) * 8 +: 8] = v;
        endfunction

        function void step_pos();
            pos++;
            if (pos >= 256)
            begin
                cv = compress(cv, blk);
                pos = 0;
            end
        endfunction

        function void note_input(logic [7:0] d, logic [3:0] cnt_in, logic eom);
            blk_t         zero;
            int unsigned  cnt;
            int unsigned  n;
            logic [7:0]   keep;
            word_t        h;
            digest_byte_t e;
            if (!open)
            begin
                foreach (zero[i]) zero[i] = '0;
                foreach (cv[i]) cv[i] = '0;
                cv[0] = 64'd64;
                cv[1] = 64'(eff_bits());
                cv = compress(cv, zero);
                pos = 0;
                open = 1;
            end
            cnt = (cnt_in > 8 || !eom) ? 8 : cnt_in;
            if (!eom)
            begin
                put(pos, d);
                step_pos();
                return;
            end
            if (cnt == 8)
            begin
                put(pos, d);
                step_pos();
                put(pos, 8'h80);
            end
            else
            begin
                keep = 8'hFF << (8 - cnt);
                put(pos, (d & keep) | (8'h80 >> cnt));
            end
            for (int unsigned p = pos + 1; p < 256; p++)
                put(p, 8'h00);
            cv = compress(cv, blk);
            pos = 0;
            open = 0;
            digests++;
            n = eff_bits() >> 3;
            for (int unsigned i = 0; i < n; i++)
            begin
                h = cv[i >> 3] ^ cv[(i >> 3) + 8];
                e.hash_byte = h[(i & 7) * 8 +: 8];
                e.last_byte = (i + 1 == n);
                digest_q.push_back(e);
            end
        endfunction

        function void check_result(logic [7:0] hb, logic lb);
            digest_byte_t e;
            if (digest_q.size() == 0)
            begin
                $error("unexpected digest byte hash_byte=%h last_byte=%b", hb, lb);
                errors++;
                return;
            end
            e = digest_q.pop_front();
            bytes_checked++;
            if (hb !== e.hash_byte)
            begin
                $error("hash_byte expected %h actual %h", e.hash_byte, hb);
                errors++;
            end
            if (lb !== e.last_byte)
            begin
                $error("last_byte expected %b actual %b", e.last_byte, lb);
                errors++;
            end
        endfunction
    endclass

    logic       clk;
    logic       rst_n;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [9:0] cfg_data;
    logic       in_valid;
    logic       in_ready;
    logic [7:0] data_byte;
    logic [3:0] bit_count;
    logic       end_of_message;
    logic       out_valid;
    logic       out_ready;
    logic [7:0] hash_byte;
    logic       last_byte;

    lsh_scoreboard sb;
    bit            idle_on;
    int            stall_left;
    int            req_count;

    lsh512_hash_engine uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .data_byte      (data_byte),
        .bit_count      (bit_count),
        .end_of_message (end_of_message),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .hash_byte      (hash_byte),
        .last_byte      (last_byte)
    );

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (!idle_on || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    always @(negedge clk)
    begin
        if (!rst_n)
            out_ready = 1'b0;
        else if (stall_left > 0)
        begin
            out_ready = 1'b0;
            stall_left--;
        end
        else if (!idle_on || $urandom_range(0, 99) < 65)
            out_ready = 1'b1;
        else
        begin
            out_ready = 1'b0;
            stall_left = gap_len();
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_result(hash_byte, last_byte);
    end

    task automatic send_byte(logic [7:0] d, logic [3:0] c, logic eom);
        int g;
        @(negedge clk);
        in_valid = 1'b1;
        data_byte = d;
        bit_count = c;
        end_of_message = eom;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_input(d, c, eom);
        req_count++;
        g = gap_len();
        if (g > 0)
        begin
            @(negedge clk);
            in_valid = 1'b0;
            repeat (g - 1) @(negedge clk);
        end
    endtask

    task automatic idle_inputs();
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    task automatic drain();
        idle_inputs();
        while (sb.digest_q.size() != 0)
            @(posedge clk);
        repeat (150) @(posedge clk);
    endtask

    task automatic write_bits(logic [9:0] v);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_data = v;
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.out_bits = v;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic send_message(int len);
        for (int k = 0; k < len; k++)
        begin
            if (k == len - 1)
                send_byte(8'($urandom), 4'($urandom_range(0, 15)), 1'b1);
            else
                send_byte(8'($urandom), 4'($urandom_range(0, 15)), 1'b0);
        end
    endtask

    initial
    begin
        #40_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        logic [9:0] lengths[11];
        int         sent;
        int         len;
        lengths = '{10'd8, 10'd7, 10'd0, 10'd1023, 10'd513, 10'd12, 10'd256,
                    10'd100, 10'd384, 10'd511, 10'd512};
        sb = new();
        idle_on = 1;
        stall_left = 0;
        req_count = 0;
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        in_valid = 1'b0;
        data_byte = '0;
        bit_count = '0;
        end_of_message = 1'b0;
        out_ready = 1'b0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: empty message, full and partial final bytes, oversize counts
        send_byte(8'h00, 4'd0, 1'b1);
        send_byte(8'hFF, 4'd8, 1'b1);
        send_byte(8'h00, 4'd8, 1'b1);
        for (int c = 1; c < 8; c++)
            send_byte(8'hFF, c[3:0], 1'b1);
        send_byte(8'hA5, 4'd15, 1'b1);
        send_byte(8'h5A, 4'd3, 1'b0);
        send_byte(8'hC3, 4'd0, 1'b0);
        send_byte(8'h3C, 4'd5, 1'b1);
        send_byte(8'hFF, 4'd9, 1'b0);
        send_byte(8'h00, 4'd0, 1'b1);
        drain();

        // exactly one full block: padding spills into a new block
        for (int k = 0; k < 255; k++)
            send_byte(8'($urandom), 4'($urandom_range(0, 15)), 1'b0);
        send_byte(8'($urandom), 4'd8, 1'b1);
        drain();

        foreach (lengths[p])
        begin
            write_bits(lengths[p]);
            idle_on = (p != 2);
            sent = 0;
            while (sent < 13)
            begin
                len = $urandom_range(1, 12);
                send_message(len);
                sent += len;
                if (p == 4 && sent < 13)
                    drain();
            end
            drain();
        end
        idle_on = 1;

        $display("Covered %0d requests, %0d digests, %0d digest bytes over %0d lengths.",
                 req_count, sb.digests, sb.bytes_checked, 11);
        if (sb.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule

/* filelist.f */
rtl/core/lsh_pkg.sv
rtl/core/lsh_ctrl.sv
rtl/core/lsh_datapath.sv
rtl/core/lsh512_hash_engine.sv
dv/lsh512_hash_engine_tb.sv
